>>> rtl/core/tssq_pkg.sv
// shared types and constants for the task slot state queue
// slot lifecycle codes, request codes, sequencer states and interface widths
// no dependencies
package tssq_pkg;

   localparam int SLOTS        = 16;
   localparam int IDX_W        = $clog2(SLOTS);
   localparam int CNT_W        = $clog2(SLOTS + 1);
   localparam int SLOT_FIELD_W = 4;
   localparam int REQ_W        = 3;
   localparam int DATA_W       = 8;

   // request codes carried on req_tuser
   localparam logic [REQ_W-1:0] REQ_ENQUEUE     = 3'd0;
   localparam logic [REQ_W-1:0] REQ_CLAIM_ANY   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_CLAIM_SHORT = 3'd2;
   localparam logic [REQ_W-1:0] REQ_COMPLETE    = 3'd3;
   localparam logic [REQ_W-1:0] REQ_FAIL        = 3'd4;
   localparam logic [REQ_W-1:0] REQ_HARVEST     = 3'd5;
   localparam logic [REQ_W-1:0] REQ_RELEASE     = 3'd6;

   localparam logic CLASS_SHORT = 1'b0;

   typedef enum logic [2:0] {
      ST_FREE    = 3'd0,
      ST_QUEUED  = 3'd1,
      ST_CLAIMED = 3'd2,
      ST_DONE    = 3'd3,
      ST_FAILED  = 3'd4
   } slot_state_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_COMMIT
   } fsm_type;

   // table write port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      slot_state_type   state;
      logic             cls_en;
      logic             cls;
   } tbl_wr_type;

   // compare unit result for one visited slot
   typedef struct packed {
      logic hit;
      logic is_tgt;
   } match_type;

endpackage

>>> rtl/core/task_slot_state_queue.sv
// top level of the task slot state queue: sequencer, scan datapath and result register
// uses tssq_pkg, tssq_table and tssq_match
// stream in on req_*, one result per item on rsp_*
module task_slot_state_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [tssq_pkg::DATA_W-1:0] req_tdata,  // [3:0] slot, [4] task_class, [7:5] zero
   input  logic [tssq_pkg::REQ_W-1:0]  req_tuser,  // [2:0] req_type
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [tssq_pkg::DATA_W-1:0] rsp_tdata,  // [3:0] slot_index, [4] any_active, [7:5] zero
   output logic                        rsp_tuser   // [0] found
);
   // Each item passes through an accept cycle in the idle state, a scan that walks the slot
   // table one slot per cycle through a single shared compare unit, and a commit state that
   // writes the chosen slot and loads the result register. The scan order
   // starts at the enqueue cursor for enqueue and at slot 0 for every other request, so the
   // first hit is the slot the request wants. Complete, fail and release also scan, to pick
   // up the old state of the target slot, which keeps a running count of queued and claimed
   // slots exact; any_active is that count after the item, compared against zero. The block
   // takes an item only in its idle state. The result register holds a finished result until
   // it is taken, and an item may be accepted meanwhile; its commit waits if the previous
   // result is still unread.
   import tssq_pkg::*;

   // sequencer
   fsm_type fsm_ff, fsm_in;

   // latched item
   logic [REQ_W-1:0]        req_code_ff;
   logic [SLOT_FIELD_W-1:0] tgt_ff;
   logic                    cls_ff;

   // scan state
   logic [IDX_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             tgt_active_ff, tgt_active_in;

   // persistent state beside the table
   logic [IDX_W-1:0] cursor_ff, cursor_in;
   logic [CNT_W-1:0] active_cnt_ff, active_cnt_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [SLOT_FIELD_W-1:0] rsp_index_ff, rsp_index_in;
   logic                    rsp_active_ff, rsp_active_in;

   // control
   logic req_fire;
   logic scan_en;
   logic scan_last;
   logic out_free;
   logic commit_en;

   // datapath
   logic [IDX_W:0]       addr_sum;
   logic [IDX_W-1:0]     scan_addr;
   slot_state_type       entry_state;
   logic                 entry_cls;
   match_type            match;
   tbl_wr_type           wr;
   logic                 tgt_ok;
   logic [IDX_W:0]       next_cursor_sum;

   assign req_fire  = req_tvalid && req_tready;
   assign scan_last = (scan_cnt_ff == IDX_W'(SLOTS - 1));
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      fsm_in = fsm_ff;
      unique case (fsm_ff)
         FSM_IDLE: begin
            if (req_fire) fsm_in = FSM_SCAN;
         end
         FSM_SCAN: begin
            if (scan_last) fsm_in = FSM_COMMIT;
         end
         FSM_COMMIT: begin
            if (out_free) fsm_in = FSM_IDLE;
         end
         default: fsm_in = FSM_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      scan_en    = 1'b0;
      commit_en  = 1'b0;
      unique case (fsm_ff)
         FSM_IDLE:   req_tready = 1'b1;
         FSM_SCAN:   scan_en    = 1'b1;
         FSM_COMMIT: commit_en  = out_free;
         default: begin
         end
      endcase
   end

   // enqueue walks from the cursor with wraparound, others from slot 0
   always_comb begin
      addr_sum = {1'b0, cursor_ff} + {1'b0, scan_cnt_ff};
      if (req_code_ff == REQ_ENQUEUE) begin
         if (addr_sum >= (IDX_W + 1)'(SLOTS)) begin
            scan_addr = IDX_W'(addr_sum - (IDX_W + 1)'(SLOTS));
         end else begin
            scan_addr = addr_sum[IDX_W-1:0];
         end
      end else begin
         scan_addr = scan_cnt_ff;
      end
   end

   tssq_match u_match (
      .req_code    (req_code_ff),
      .tgt         (tgt_ff),
      .addr        (scan_addr),
      .entry_state (entry_state),
      .entry_cls   (entry_cls),
      .result      (match)
   );

   // scan bookkeeping: first hit and old state of the named slot
   always_comb begin
      scan_cnt_in   = scan_cnt_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      tgt_active_in = tgt_active_ff;
      if (req_fire) begin
         scan_cnt_in   = '0;
         hit_in        = 1'b0;
         hit_idx_in    = '0;
         tgt_active_in = 1'b0;
      end else if (scan_en) begin
         scan_cnt_in = scan_last ? '0 : scan_cnt_ff + 1'b1;
         if (match.hit && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = scan_addr;
         end
         if (match.is_tgt) begin
            tgt_active_in = (entry_state == ST_QUEUED) || (entry_state == ST_CLAIMED);
         end
      end
   end

   // commit: table write, cursor, active count and the result
   assign tgt_ok          = ({1'b0, tgt_ff} < (SLOT_FIELD_W + 1)'(SLOTS));
   assign next_cursor_sum = {1'b0, hit_idx_ff} + 1'b1;

   always_comb begin
      wr            = '0;
      wr.state      = ST_FREE;
      cursor_in     = cursor_ff;
      active_cnt_in = active_cnt_ff;
      rsp_found_in  = 1'b0;
      rsp_index_in  = tgt_ff;
      unique case (req_code_ff)
         REQ_ENQUEUE: begin
            rsp_found_in = hit_ff;
            rsp_index_in = SLOT_FIELD_W'(hit_idx_ff);
            if (hit_ff) begin
               wr.en         = 1'b1;
               wr.addr       = hit_idx_ff;
               wr.state      = ST_QUEUED;
               wr.cls_en     = 1'b1;
               wr.cls        = cls_ff;
               active_cnt_in = active_cnt_ff + 1'b1;
               if (next_cursor_sum >= (IDX_W + 1)'(SLOTS)) begin
                  cursor_in = '0;
               end else begin
                  cursor_in = next_cursor_sum[IDX_W-1:0];
               end
            end
         end
         REQ_CLAIM_ANY, REQ_CLAIM_SHORT: begin
            // queued to claimed keeps the slot active
            rsp_found_in = hit_ff;
            rsp_index_in = SLOT_FIELD_W'(hit_idx_ff);
            wr.en        = hit_ff;
            wr.addr      = hit_idx_ff;
            wr.state     = ST_CLAIMED;
         end
         REQ_HARVEST: begin
            rsp_found_in = hit_ff;
            rsp_index_in = SLOT_FIELD_W'(hit_idx_ff);
         end
         REQ_COMPLETE, REQ_FAIL, REQ_RELEASE: begin
            rsp_found_in = tgt_ok;
            if (tgt_ok) begin
               wr.en   = 1'b1;
               wr.addr = IDX_W'(tgt_ff);
               if (req_code_ff == REQ_COMPLETE) begin
                  wr.state = ST_DONE;
               end else if (req_code_ff == REQ_FAIL) begin
                  wr.state = ST_FAILED;
               end else begin
                  wr.state = ST_FREE;
               end
               // none of the new states is active
               active_cnt_in = active_cnt_ff - CNT_W'(tgt_active_ff);
            end
         end
         default: begin
            // unknown request: echo the slot, change nothing
         end
      endcase
      rsp_active_in = (active_cnt_in != '0);
      if (!commit_en) begin
         wr.en         = 1'b0;
         cursor_in     = cursor_ff;
         active_cnt_in = active_cnt_ff;
      end
   end

   tssq_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (scan_addr),
      .rd_state (entry_state),
      .rd_cls   (entry_cls),
      .wr       (wr)
   );

   // result valid: set by a commit, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= FSM_IDLE;
         scan_cnt_ff   <= '0;
         hit_ff        <= 1'b0;
         cursor_ff     <= '0;
         active_cnt_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fsm_ff        <= fsm_in;
         scan_cnt_ff   <= scan_cnt_in;
         hit_ff        <= hit_in;
         cursor_ff     <= cursor_in;
         active_cnt_ff <= active_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hit_idx_ff    <= hit_idx_in;
      tgt_active_ff <= tgt_active_in;
      if (req_fire) begin
         req_code_ff <= req_tuser;
         tgt_ff      <= req_tdata[SLOT_FIELD_W-1:0];
         cls_ff      <= req_tdata[SLOT_FIELD_W];
      end
      if (commit_en) begin
         rsp_found_ff  <= rsp_found_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_active_ff <= rsp_active_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {(DATA_W - SLOT_FIELD_W - 1)'(0), rsp_active_ff, rsp_index_ff};

   // active count never exceeds the number of slots
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      active_cnt_ff <= CNT_W'(SLOTS))
      else $error("active slot count out of range");

   // enqueue cursor stays inside the table
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff < IDX_W'(SLOTS - 1) || cursor_ff == IDX_W'(SLOTS - 1))
      else $error("enqueue cursor out of range");

   // a new result only appears right after a commit
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(fsm_ff == FSM_COMMIT))
      else $error("result raised outside commit");

   // the table is written only in the commit cycle
   a_write_in_commit: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> fsm_ff == FSM_COMMIT)
      else $error("table write outside commit");

endmodule

>>> rtl/core/tssq_table.sv
// slot table storage: lifecycle state and class bit per slot
// one read address, one write port; depends on tssq_pkg
module tssq_table (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [tssq_pkg::IDX_W-1:0] rd_addr,
   output tssq_pkg::slot_state_type rd_state,
   output logic                     rd_cls,
   input  tssq_pkg::tbl_wr_type     wr
);
   import tssq_pkg::*;

   slot_state_type state_mem_ff [SLOTS];
   logic           class_mem_ff [SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            state_mem_ff[i] <= ST_FREE;
         end
      end else if (wr.en) begin
         state_mem_ff[wr.addr] <= wr.state;
      end
   end

   // class bit is only ever read on a queued slot, which an enqueue wrote
   always_ff @(posedge clock) begin
      if (wr.en && wr.cls_en) begin
         class_mem_ff[wr.addr] <= wr.cls;
      end
   end

   assign rd_state = state_mem_ff[rd_addr];
   assign rd_cls   = class_mem_ff[rd_addr];

endmodule

>>> rtl/core/tssq_match.sv
// shared compare unit applied to one slot per scan cycle
// decides search hit and target match for the current request; depends on tssq_pkg
module tssq_match (
   input  logic [tssq_pkg::REQ_W-1:0]        req_code,
   input  logic [tssq_pkg::SLOT_FIELD_W-1:0] tgt,
   input  logic [tssq_pkg::IDX_W-1:0]        addr,
   input  tssq_pkg::slot_state_type          entry_state,
   input  logic                              entry_cls,
   output tssq_pkg::match_type               result
);
   import tssq_pkg::*;

   always_comb begin
      result.is_tgt = ({1'b0, tgt} == (SLOT_FIELD_W + 1)'(addr));
      unique case (req_code)
         REQ_ENQUEUE:     result.hit = (entry_state == ST_FREE);
         REQ_CLAIM_ANY:   result.hit = (entry_state == ST_QUEUED);
         REQ_CLAIM_SHORT: result.hit = (entry_state == ST_QUEUED) && (entry_cls == CLASS_SHORT);
         REQ_HARVEST:     result.hit = (entry_state == ST_DONE) || (entry_state == ST_FAILED);
         default:         result.hit = 1'b0;
      endcase
   end

endmodule
